>>> sv/bvi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvi_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF         = 64;
	localparam int ELEMENT_WIDTH_DEF = 32;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Fixed field widths of the channels
	localparam int COMMAND_W  = 3;
	localparam int POSITION_W = 7;
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;

	// Command codes on the input channel
	localparam logic [COMMAND_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [COMMAND_W-1:0] CMD_POP    = 3'd1;
	localparam logic [COMMAND_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [COMMAND_W-1:0] CMD_READ   = 3'd3;
	localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 3'd4;

	// Decoded operation carried through the queue
	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_INSERT,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// One queued command
	typedef struct packed {
		op_t                   op;
		logic [POSITION_W-1:0] position;
		logic [VALUE_W-1:0]    value;
	} cmd_t;

endpackage

`default_nettype wire

>>> sv/bvi_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface bvi_cmd_if;
	import bvi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COMMAND_W-1:0]  command;
	logic [POSITION_W-1:0] position;
	logic [VALUE_W-1:0]    value_in;

	modport source (output valid, command, position, value_in, input ready);
	modport sink   (input valid, command, position, value_in, output ready);
endinterface

// Result channel
interface bvi_rsp_if;
	import bvi_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VALUE_W-1:0]   read_value;
	logic [COUNT_W-1:0]   fill_count;
	logic [VALUE_W-1:0]   first_value;
	logic [VALUE_W-1:0]   last_value;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, read_value, fill_count, first_value, last_value, status,
		input ready);
	modport sink   (input valid, read_value, fill_count, first_value, last_value, status,
		output ready);
endinterface

`default_nettype wire

>>> sv/bvi_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bvi_front (
	input  logic          clk,
	input  logic          arst_n,
	bvi_cmd_if.sink       cmd,
	output bvi_pkg::cmd_t q_head,
	output logic          q_valid,
	input  logic          q_pop
);
	import bvi_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] used_q;
	op_t            op_dec;
	logic           push;
	logic           pop;

	// Classify the incoming command
	always_comb begin
		unique case (cmd.command)
			CMD_PUSH:   op_dec = OP_PUSH;
			CMD_POP:    op_dec = OP_POP;
			CMD_INSERT: op_dec = OP_INSERT;
			CMD_READ:   op_dec = OP_READ;
			CMD_CLEAR:  op_dec = OP_CLEAR;
			default:    op_dec = OP_NONE;
		endcase
	end

	assign cmd.ready = (used_q != QCW'(QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (used_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_head    = slot_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op_dec, position: cmd.position, value: cmd.value_in};
		end
	end

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				used_q <= used_q + 1'b1;
			end else if (pop && !push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= QCW'(QUEUE_DEPTH))
		else $error("command queue overfilled");

endmodule

`default_nettype wire

>>> sv/bvi_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bvi_back #(
	parameter int DEPTH         = bvi_pkg::DEPTH_DEF,
	parameter int ELEMENT_WIDTH = bvi_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bvi_pkg::cmd_t q_head,
	input  logic          q_valid,
	output logic          q_pop,
	bvi_rsp_if.source     rsp
);
	import bvi_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PLACE,
		S_FETCH,
		S_DONE
	} state_t;

	// Element to result field: truncate or zero-extend to the channel width
	function automatic logic [VALUE_W-1:0] to_out(input logic [ELEMENT_WIDTH-1:0] x);
		logic [63:0] w;
		w = 64'(x);
		return w[VALUE_W-1:0];
	endfunction

	logic [ELEMENT_WIDTH-1:0] mem [DEPTH];
	logic [ELEMENT_WIDTH-1:0] rd_data_q;

	state_t                   state_q;
	op_t                      op_q;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            idx_q;
	logic [ELEMENT_WIDTH-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic [ELEMENT_WIDTH-1:0] first_q;
	logic [ELEMENT_WIDTH-1:0] last_q;
	logic [ELEMENT_WIDTH-1:0] rdval_q;
	status_t                  status_q;
	logic                     out_valid_q;
	logic [VALUE_W-1:0]       read_value_q;
	logic [COUNT_W-1:0]       fill_count_q;
	logic [VALUE_W-1:0]       first_value_q;
	logic [VALUE_W-1:0]       last_value_q;
	status_t                  rsp_status_q;

	logic                     take;
	logic                     full;
	logic                     shift_last;
	logic [ELEMENT_WIDTH-1:0] head_val;
	logic [CMPW-1:0]          head_pos;
	logic [CMPW-1:0]          cnt_w;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [ELEMENT_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]            mem_raddr;

	assign head_val   = ELEMENT_WIDTH'(q_head.value);
	assign head_pos   = CMPW'(q_head.position);
	assign cnt_w      = CMPW'(count_q);
	assign full       = (count_q == CW'(DEPTH));
	assign take       = (state_q == S_IDLE) && q_valid && !out_valid_q;
	assign q_pop      = take;
	assign shift_last = (idx_q == pos_q + 1'b1);

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.fill_count  = fill_count_q;
	assign rsp.first_value = first_value_q;
	assign rsp.last_value  = last_value_q;
	assign rsp.status      = rsp_status_q;

	// Store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = head_val;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (q_head.op)
						OP_PUSH: begin
							mem_we = !full;
						end
						OP_POP: begin
							mem_raddr = AW'(count_q - CW'(2));
						end
						OP_INSERT: begin
							if (head_pos == cnt_w) begin
								mem_we = !full;
							end else begin
								mem_raddr = AW'(count_q - CW'(1));
							end
						end
						OP_READ: begin
							mem_raddr = head_pos[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = rd_data_q;
				mem_raddr = shift_last ? '0 : idx_q - AW'(2);
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	// Entry store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// Sequencer, fill count, end values and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_NONE;
			pos_q         <= '0;
			idx_q         <= '0;
			val_q         <= '0;
			count_q       <= '0;
			first_q       <= '0;
			last_q        <= '0;
			rdval_q       <= '0;
			status_q      <= ST_OK;
			out_valid_q   <= 1'b0;
			read_value_q  <= '0;
			fill_count_q  <= '0;
			first_value_q <= '0;
			last_value_q  <= '0;
			rsp_status_q  <= ST_OK;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						op_q    <= q_head.op;
						pos_q   <= head_pos[AW-1:0];
						val_q   <= head_val;
						rdval_q <= '0;
						unique case (q_head.op)
							OP_PUSH: begin
								state_q <= S_DONE;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + 1'b1;
									last_q   <= head_val;
									if (count_q == '0) begin
										first_q <= head_val;
									end
								end
							end
							OP_POP: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q - 1'b1;
									if (count_q >= CW'(2)) begin
										state_q <= S_FETCH;
									end else begin
										state_q <= S_DONE;
									end
								end
							end
							OP_INSERT: begin
								priority if (head_pos > cnt_w) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (head_pos == cnt_w) begin
									// append at the end
									status_q <= ST_OK;
									state_q  <= S_DONE;
									count_q  <= count_q + 1'b1;
									last_q   <= head_val;
									if (count_q == '0) begin
										first_q <= head_val;
									end
								end else begin
									status_q <= ST_OK;
									idx_q    <= count_q[AW-1:0];
									state_q  <= S_SHIFT;
								end
							end
							OP_READ: begin
								if (head_pos >= cnt_w) begin
									status_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_FETCH;
								end
							end
							OP_CLEAR: begin
								status_q <= ST_OK;
								state_q  <= S_DONE;
								count_q  <= '0;
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				// one entry moves up per cycle, top down
				S_SHIFT: begin
					if (shift_last) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_PLACE: begin
					count_q <= count_q + 1'b1;
					if (pos_q == '0) begin
						first_q <= val_q;
					end
					state_q <= S_DONE;
				end
				S_FETCH: begin
					if (op_q == OP_READ) begin
						rdval_q <= rd_data_q;
					end else begin
						last_q <= rd_data_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					read_value_q  <= to_out(rdval_q);
					fill_count_q  <= COUNT_W'(count_q);
					first_value_q <= (count_q == '0) ? '0 : to_out(first_q);
					last_value_q  <= (count_q == '0) ? '0 : to_out(last_q);
					rsp_status_q  <= status_q;
					out_valid_q   <= 1'b1;
					state_q       <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> idx_q > pos_q)
		else $error("shift index at or below insert position");

	a_place_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the count");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> rsp.valid)
		else $error("finished command gave no result");

endmodule

`default_nettype wire

>>> sv/bounded_vector_with_insert_unit.sv
// Bounded vector with insert.
// Commands arrive on the cmd channel (valid/ready, a transaction when both are
// high): push, pop, insert at position, read at position, clear. Each command
// gives exactly one transaction on the rsp channel carrying the read value, the
// fill count and the first and last entries after the command, plus a status.
// A two-entry command queue takes transactions independently of the executor,
// so cmd stays ready while a result waits on rsp.
// Execution, from leaving the queue to the result register (one store with
// one write and one registered read port), runs through these states:
//   push, clear, insert at the count, a pop that empties the store,
//   refused or unused commands: S_DONE only
//   read in range, a pop that leaves entries: S_FETCH (one store read), S_DONE
//   insert below the count: S_SHIFT, then S_PLACE and S_DONE; count - position
//   entries moved, one entry per cycle
// The executor starts the next command once the result has been taken; a
// receiver that holds rsp.ready low stalls execution and, once the queue is
// full, cmd.ready drops. Reset empties the queue and the store (count zero);
// the entries themselves are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module bounded_vector_with_insert_unit #(
	parameter int DEPTH         = bvi_pkg::DEPTH_DEF,
	parameter int ELEMENT_WIDTH = bvi_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bvi_cmd_if.sink   cmd,
	bvi_rsp_if.source rsp
);
	import bvi_pkg::*;

	cmd_t q_head;
	logic q_valid;
	logic q_pop;

	bvi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	bvi_back #(
		.DEPTH         (DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
